@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock, off during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication with a non-overlapping consequent (|=>)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ hdl/gaec_pkg.sv @@
// ----------------------------------------------------------------------------
// gaec_pkg: shared types and constants
// Widths, op codes, direction codes and controller/datapath command structs.
// ----------------------------------------------------------------------------
`default_nettype none
package gaec_pkg;
   localparam int MAX_LEN     = 64;
   localparam int SYMBOL_BITS = 8;
   localparam int IDX_W   = $clog2(MAX_LEN);
   localparam int CNT_W   = $clog2(MAX_LEN + 1);
   localparam int DIR_AW  = 2 * IDX_W;
   localparam int SCORE_W = 14;
   localparam int OUT_W   = 7;
   localparam int CFG_W   = 6;

   localparam logic [1:0] OP_LOAD_A = 2'd0;
   localparam logic [1:0] OP_LOAD_B = 2'd1;
   localparam logic [1:0] OP_RUN    = 2'd2;

   localparam logic [1:0] CSR_MATCH    = 2'd0;
   localparam logic [1:0] CSR_MISMATCH = 2'd1;
   localparam logic [1:0] CSR_GAP      = 2'd2;

   localparam logic [1:0] DIR_MATCH  = 2'd0;
   localparam logic [1:0] DIR_DELETE = 2'd1;
   localparam logic [1:0] DIR_INSERT = 2'd2;

   typedef struct packed {
      logic load_a;      // write symbol to first sequence
      logic load_b;
      logic init;        // start run: latch lengths, set row 0
      logic fill_issue;  // issue reads for cell (i,j)
      logic fill_cell;   // compute and write cell
      logic row_start;   // begin row i
      logic tb_start;
      logic tb_step;     // apply traceback step
      logic finish;      // add leftovers, clear sequences
   } cmd_type;

   typedef struct packed {
      logic a_full;
      logic b_full;
      logic row_done;    // j passed l2
      logic fill_done;   // i reached l1
      logic tb_done;     // i or j zero
   } status_type;
endpackage
`default_nettype wire

@@ hdl/global_alignment_edit_counter.sv @@
// ----------------------------------------------------------------------------
// global_alignment_edit_counter: Needleman-Wunsch edit counter
// Loads two sequences, fills the score grid and counts traceback edits.
//
//   channel | dir | ports
//   req     | in  | req_valid req_stall req_op req_symbol
//   rsp     | out | rsp_valid rsp_stall rsp_*_count rsp_first_length rsp_overflow
//   csr     | in  | csr_write csr_index csr_data
//
// A load word is taken while idle. After the run word is taken the controller
// sweeps row 0, then handles each grid cell as a read step and a compute/write
// step of the score-row memory, each row adding its check, start and final read
// steps, then walks at most l1 + l2 traceback steps before the result is valid.
// Reset is synchronous and clears the sequence lengths and overflow.
// The request side stalls from a run until its result word is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module global_alignment_edit_counter (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_op,
   input  wire logic [7:0] req_symbol,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [6:0]      rsp_match_count,
   output logic [6:0]      rsp_mismatch_count,
   output logic [6:0]      rsp_deletion_count,
   output logic [6:0]      rsp_insertion_count,
   output logic [6:0]      rsp_first_length,
   output logic            rsp_overflow,
   input  wire logic       csr_write,
   input  wire logic [1:0] csr_index,
   input  wire logic [5:0] csr_data
);
   import gaec_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       cap;
   logic signed [CFG_W-1:0] ma_ff, mm_ff, gp_ff;
   logic [OUT_W-1:0] nm, nmm, nd, ni, fl;
   logic             ovf;
   logic [CNT_W-1:0] l2_cnt;
   logic [CNT_W-1:0] u_dp_l2;

   // hold config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ma_ff <= 6'sd1; mm_ff <= -6'sd2; gp_ff <= -6'sd2;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MATCH:    ma_ff <= csr_data;
            CSR_MISMATCH: mm_ff <= csr_data;
            CSR_GAP:      gp_ff <= csr_data;
            default: ;
         endcase
      end
   end

   gaec_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_op,
      .rsp_valid, .rsp_stall, .l2(l2_cnt), .cmd, .status, .cap);

   gaec_datapath u_dp (
      .clock, .reset, .cmd, .status, .symbol(req_symbol[SYMBOL_BITS-1:0]),
      .ma(ma_ff), .mm(mm_ff), .gp(gp_ff),
      .n_match(nm), .n_mismatch(nmm), .n_delete(nd), .n_insert(ni),
      .first_len(fl), .ovf(ovf));

   assign l2_cnt = u_dp_l2;
   // second count tracked here for the row-0 sweep length
   always_ff @(posedge clock) begin
      if (reset) u_dp_l2 <= '0;
      else if (cmd.finish) u_dp_l2 <= '0;
      else if (cmd.load_b && !status.b_full) u_dp_l2 <= u_dp_l2 + CNT_W'(1);
   end

   // capture the result word; overflow taken before finish clears it
   always_ff @(posedge clock) begin
      if (cap) begin
         rsp_match_count     <= nm;
         rsp_mismatch_count  <= nmm;
         rsp_deletion_count  <= nd + OUT_W'(0);
         rsp_insertion_count <= ni;
         rsp_first_length    <= fl;
         rsp_overflow        <= ovf;
      end
   end

   `ASSERT_IMPLY(a_busy_stall, clock, reset, rsp_valid, req_stall,
      "request taken while result pending")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid,
      "result dropped while stalled")
endmodule
`default_nettype wire

@@ hdl/gaec_ram.sv @@
// ----------------------------------------------------------------------------
// gaec_ram: generic single-write RAM with registered read
// One write port and one read port.
// ----------------------------------------------------------------------------
`default_nettype none
module gaec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ hdl/gaec_datapath.sv @@
// ----------------------------------------------------------------------------
// gaec_datapath: sequence stores, score row, direction store and counters
// Fills one cell at a time (read, then compute/write), then walks the traceback.
// ----------------------------------------------------------------------------
`default_nettype none
module gaec_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gaec_pkg::cmd_type             cmd,
   output gaec_pkg::status_type               status,
   input  wire logic [gaec_pkg::SYMBOL_BITS-1:0] symbol,
   input  wire logic signed [gaec_pkg::CFG_W-1:0] ma,
   input  wire logic signed [gaec_pkg::CFG_W-1:0] mm,
   input  wire logic signed [gaec_pkg::CFG_W-1:0] gp,
   output logic [gaec_pkg::OUT_W-1:0]         n_match,
   output logic [gaec_pkg::OUT_W-1:0]         n_mismatch,
   output logic [gaec_pkg::OUT_W-1:0]         n_delete,
   output logic [gaec_pkg::OUT_W-1:0]         n_insert,
   output logic [gaec_pkg::OUT_W-1:0]         first_len,
   output logic                               ovf
);
   import gaec_pkg::*;

   logic [CNT_W-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] l1_ff, l1_in, l2_ff, l2_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in;
   logic signed [SCORE_W-1:0] diag_ff, diag_in, left_ff, left_in, rowbase_ff, rowbase_in;
   logic [OUT_W-1:0] nm_ff, nm_in, nmm_ff, nmm_in, nd_ff, nd_in, ni_ff, ni_in;

   // memories
   logic [SYMBOL_BITS-1:0] a_rd, b_rd;
   logic [IDX_W-1:0]       a_raddr, b_raddr;
   logic                   row_we;
   logic [CNT_W-1:0]       row_waddr;
   logic [SCORE_W-1:0]     row_wdata, row_rd;
   logic                   dir_we;
   logic [DIR_AW-1:0]      dir_addr_w, dir_addr_r;
   logic [1:0]             dir_wdata, dir_rd;

   logic [CNT_W-1:0] im1, jm1;
   assign im1 = i_ff - CNT_W'(1);
   assign jm1 = j_ff - CNT_W'(1);

   gaec_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_LEN)) u_seq_a (
      .clock, .wr_en(cmd.load_a && !status.a_full), .wr_addr(cnt_a_ff[IDX_W-1:0]),
      .wr_data(symbol), .rd_addr(a_raddr), .rd_data(a_rd));
   gaec_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_LEN)) u_seq_b (
      .clock, .wr_en(cmd.load_b && !status.b_full), .wr_addr(cnt_b_ff[IDX_W-1:0]),
      .wr_data(symbol), .rd_addr(b_raddr), .rd_data(b_rd));
   gaec_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_LEN + 1)) u_row (
      .clock, .wr_en(row_we), .wr_addr(row_waddr), .wr_data(row_wdata),
      .rd_addr(j_ff), .rd_data(row_rd));
   gaec_ram #(.WIDTH(2), .DEPTH(MAX_LEN * MAX_LEN)) u_dir (
      .clock, .wr_en(dir_we), .wr_addr(dir_addr_w), .wr_data(dir_wdata),
      .rd_addr(dir_addr_r), .rd_data(dir_rd));

   assign a_raddr    = im1[IDX_W-1:0];
   assign b_raddr    = jm1[IDX_W-1:0];
   assign dir_addr_r = {im1[IDX_W-1:0], jm1[IDX_W-1:0]};
   assign dir_addr_w = dir_addr_r;

   // cell arithmetic
   logic signed [SCORE_W-1:0] sm, sd, si, best;
   logic                      eq;
   assign eq   = (a_rd == b_rd);
   assign sm   = diag_ff + SCORE_W'(eq ? ma : mm);
   assign sd   = $signed(row_rd) + SCORE_W'(gp);
   assign si   = left_ff + SCORE_W'(gp);
   always_comb begin
      best = sm;
      if (sd > best) best = sd;
      if (si > best) best = si;
      priority if (best == sd) dir_wdata = DIR_DELETE;
      else if (best == si)     dir_wdata = DIR_INSERT;
      else                     dir_wdata = DIR_MATCH;
   end
   assign dir_we = cmd.fill_cell;

   // row 0 is written with j*gp during init by sweeping; j=0 entry holds i*gp
   always_comb begin
      row_we    = 1'b0;
      row_waddr = j_ff;
      row_wdata = best;
      if (cmd.init || cmd.row_start) begin
         row_we    = 1'b1;
         row_wdata = cmd.init ? left_in : rowbase_in;
         row_waddr = cmd.init ? j_ff : '0;
      end else if (cmd.fill_cell) begin
         row_we = 1'b1;
      end
   end

   always_comb begin
      cnt_a_in = cnt_a_ff; cnt_b_in = cnt_b_ff; ovf_in = ovf_ff;
      l1_in = l1_ff; l2_in = l2_ff; i_in = i_ff; j_in = j_ff;
      diag_in = diag_ff; left_in = left_ff; rowbase_in = rowbase_ff;
      nm_in = nm_ff; nmm_in = nmm_ff; nd_in = nd_ff; ni_in = ni_ff;
      if (cmd.load_a) begin
         if (status.a_full) ovf_in = 1'b1; else cnt_a_in = cnt_a_ff + CNT_W'(1);
      end
      if (cmd.load_b) begin
         if (status.b_full) ovf_in = 1'b1; else cnt_b_in = cnt_b_ff + CNT_W'(1);
      end
      if (cmd.init) begin
         // sweep row 0: j runs 0..l2, left holds j*gp
         if (j_ff == '0 && left_ff == '0) begin
            l1_in = cnt_a_ff; l2_in = cnt_b_ff;
         end
         left_in = (j_ff == '0) ? '0 : left_ff + SCORE_W'(gp);
         j_in    = j_ff + CNT_W'(1);
      end
      if (cmd.row_start) begin
         // row i: left and column 0 = i*gp; diag = previous column 0
         diag_in    = rowbase_ff;
         rowbase_in = rowbase_ff + SCORE_W'(gp);
         left_in    = rowbase_ff + SCORE_W'(gp);
         i_in       = i_ff + CNT_W'(1);
         j_in       = CNT_W'(1);
      end
      if (cmd.fill_cell) begin
         diag_in = $signed(row_rd);
         left_in = best;
         j_in    = j_ff + CNT_W'(1);
      end
      if (cmd.tb_start) begin
         i_in = l1_ff; j_in = l2_ff;
         nm_in = '0; nmm_in = '0; nd_in = '0; ni_in = '0;
      end
      if (cmd.tb_step) begin
         unique case (dir_rd)
            DIR_DELETE: begin i_in = im1; nd_in = nd_ff + OUT_W'(1); end
            DIR_INSERT: begin j_in = jm1; ni_in = ni_ff + OUT_W'(1); end
            default: begin
               i_in = im1; j_in = jm1;
               if (eq) nm_in = nm_ff + OUT_W'(1); else nmm_in = nmm_ff + OUT_W'(1);
            end
         endcase
      end
      if (cmd.finish) begin
         nd_in = nd_ff + OUT_W'(i_ff);
         ni_in = ni_ff + OUT_W'(j_ff);
         cnt_a_in = '0; cnt_b_in = '0; ovf_in = 1'b0;
         j_in = '0; left_in = '0; i_in = '0; rowbase_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff <= '0; cnt_b_ff <= '0; ovf_ff <= 1'b0;
         i_ff <= '0; j_ff <= '0; left_ff <= '0; rowbase_ff <= '0;
      end else begin
         cnt_a_ff <= cnt_a_in; cnt_b_ff <= cnt_b_in; ovf_ff <= ovf_in;
         i_ff <= i_in; j_ff <= j_in; left_ff <= left_in; rowbase_ff <= rowbase_in;
      end
      l1_ff <= l1_in; l2_ff <= l2_in; diag_ff <= diag_in;
      nm_ff <= nm_in; nmm_ff <= nmm_in; nd_ff <= nd_in; ni_ff <= ni_in;
   end

   assign status.a_full    = (cnt_a_ff == CNT_W'(MAX_LEN));
   assign status.b_full    = (cnt_b_ff == CNT_W'(MAX_LEN));
   assign status.row_done  = (j_ff > l2_ff);
   assign status.fill_done = (i_ff == l1_ff);
   assign status.tb_done   = (i_ff == '0) || (j_ff == '0);

   // gap counts include the leftover edge cells while finish is up
   assign n_match    = nm_ff;
   assign n_mismatch = nmm_ff;
   assign n_delete   = nd_in;
   assign n_insert   = ni_in;
   assign first_len  = OUT_W'(l1_ff);
   assign ovf        = ovf_ff;
endmodule
`default_nettype wire

@@ hdl/gaec_ctrl.sv @@
// ----------------------------------------------------------------------------
// gaec_ctrl: run sequencer
// Takes words, steps fill and traceback, presents the result word.
// ----------------------------------------------------------------------------
`default_nettype none
module gaec_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_op,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire logic [gaec_pkg::CNT_W-1:0] l2,
   output gaec_pkg::cmd_type         cmd,
   input  wire gaec_pkg::status_type status,
   output logic                      cap
);
   import gaec_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_INIT = 4'd1, S_ROW = 4'd2, S_RD = 4'd3,
                          S_CELL = 4'd4, S_TBS = 4'd5, S_TBR = 4'd6, S_TBW = 4'd7,
                          S_FIN = 4'd8, S_OUT = 4'd9, S_CHK = 4'd10;
   logic [3:0] state_ff, state_in;
   logic [gaec_pkg::CNT_W-1:0] sweep_ff, sweep_in;
   logic acc;

   assign req_stall = (state_ff != S_IDLE);
   assign acc       = req_valid && !req_stall;
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      cmd = '0; state_in = state_ff; sweep_in = sweep_ff; cap = 1'b0;
      unique case (state_ff)
         S_IDLE: if (acc) begin
            cmd.load_a = (req_op == OP_LOAD_A);
            cmd.load_b = (req_op == OP_LOAD_B);
            if (req_op == OP_RUN) begin
               cmd.init = 1'b1; sweep_in = '0; state_in = S_INIT;
            end
         end
         S_INIT: begin
            // sweep j = 1..l2 of row 0
            if (sweep_ff >= l2) state_in = S_CHK;
            else begin cmd.init = 1'b1; sweep_in = sweep_ff + CNT_W'(1); end
         end
         S_CHK: state_in = status.fill_done ? S_TBS : S_ROW;
         S_ROW: begin cmd.row_start = 1'b1; state_in = S_RD; end
         S_RD: begin
            if (status.row_done) state_in = S_CHK;
            else begin cmd.fill_issue = 1'b1; state_in = S_CELL; end
         end
         S_CELL: begin cmd.fill_cell = 1'b1; state_in = S_RD; end
         S_TBS: begin cmd.tb_start = 1'b1; state_in = S_TBR; end
         S_TBR: state_in = status.tb_done ? S_FIN : S_TBW;
         S_TBW: begin cmd.tb_step = 1'b1; state_in = S_TBR; end
         S_FIN: begin cmd.finish = 1'b1; cap = 1'b1; state_in = S_OUT; end
         S_OUT: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; sweep_ff <= '0;
      end else begin
         state_ff <= state_in; sweep_ff <= sweep_in;
      end
   end
endmodule
`default_nettype wire
